FILE: src/mbc1_pkg.sv
// ----------------------------------------------------------------------------
// MBC1 bank controller package
// Shared types, constants and the ROM-size mask function used by the bank
// controller modules.
// ----------------------------------------------------------------------------
package mbc1_pkg;

   localparam int OFFSET_WIDTH   = 14;
   localparam int LOW_BANK_WIDTH = 5;
   localparam int HIGH_BANK_WIDTH = 2;
   localparam int BANK_WIDTH     = LOW_BANK_WIDTH + HIGH_BANK_WIDTH;
   localparam int ROM_ADDR_WIDTH = BANK_WIDTH + OFFSET_WIDTH;
   localparam int SIZE_WIDTH     = 3;

   // ROM size codes that matter to the logic.
   localparam logic [SIZE_WIDTH-1:0] SIZE_CODE_32K  = 3'd0;
   localparam logic [SIZE_WIDTH-1:0] SIZE_CODE_64K  = 3'd1;
   localparam logic [SIZE_WIDTH-1:0] SIZE_CODE_128K = 3'd2;
   localparam logic [SIZE_WIDTH-1:0] SIZE_CODE_256K = 3'd3;
   localparam logic [SIZE_WIDTH-1:0] SIZE_CODE_1M   = 3'd5;
   localparam logic [SIZE_WIDTH-1:0] SIZE_CODE_2M   = 3'd6;

   // 8 KiB regions of the CPU bus, selected by address bits 15:13.
   localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
   localparam logic [2:0] REGION_LOW_BANK   = 3'd1;
   localparam logic [2:0] REGION_HIGH_BANK  = 3'd2;
   localparam logic [2:0] REGION_MODE       = 3'd3;
   localparam logic [2:0] REGION_RAM_WINDOW = 3'd5;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_ROM_READ   = 2'd0,
      STATUS_OPEN_BUS   = 2'd1,
      STATUS_WRITE_DONE = 2'd2,
      STATUS_UNMAPPED   = 2'd3
   } status_type;

   typedef struct packed {
      logic [LOW_BANK_WIDTH-1:0]  low_bank;
      logic [HIGH_BANK_WIDTH-1:0] high_bank;
      logic                       bank_mode;
   } bank_state_type;

   typedef struct packed {
      logic                       low_we;
      logic                       high_we;
      logic                       mode_we;
      logic [LOW_BANK_WIDTH-1:0]  low_bank;
      logic [HIGH_BANK_WIDTH-1:0] high_bank;
      logic                       bank_mode;
   } bank_update_type;

   typedef struct packed {
      logic [ROM_ADDR_WIDTH-1:0] rom_address;
      status_type                status;
   } result_type;

   // Low bank mask for each ROM size; the larger sizes all use five bits.
   function automatic logic [LOW_BANK_WIDTH-1:0] low_mask(
      input logic [SIZE_WIDTH-1:0] size_code);
      logic [LOW_BANK_WIDTH-1:0] mask;
      case (size_code)
         SIZE_CODE_32K:  mask = 5'h01;
         SIZE_CODE_64K:  mask = 5'h03;
         SIZE_CODE_128K: mask = 5'h07;
         SIZE_CODE_256K: mask = 5'h0F;
         default:        mask = 5'h1F;
      endcase
      return mask;
   endfunction

endpackage

FILE: src/mbc1_if.sv
// ----------------------------------------------------------------------------
// MBC1 bank controller channels
// Valid/ready interfaces for bus access requests and translation responses.
// ----------------------------------------------------------------------------
interface mbc1_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [15:0] bus_address;
   logic [7:0]  write_data;

   modport source (output valid, func, bus_address, write_data, input ready);
   modport sink   (input valid, func, bus_address, write_data, output ready);
endinterface

interface mbc1_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] rom_address;
   logic [1:0]  status;

   modport source (output valid, rom_address, status, input ready);
   modport sink   (input valid, rom_address, status, output ready);
endinterface

FILE: src/mbc1_decode.sv
// ----------------------------------------------------------------------------
// MBC1 access decoder
// Decodes one bus access into a response and a bank register update.
// ----------------------------------------------------------------------------
module mbc1_decode import mbc1_pkg::*; (
   input  logic                  func,
   input  logic [15:0]           bus_address,
   input  logic [7:0]            write_data,
   input  logic [SIZE_WIDTH-1:0] size_code,
   input  bank_state_type        bank,
   output result_type            result,
   output bank_update_type       update
);

   logic [OFFSET_WIDTH-1:0]   offset;
   logic [2:0]                region;
   logic                      upper_used;
   logic [LOW_BANK_WIDTH-1:0] low_eff;
   logic [BANK_WIDTH-1:0]     bank_num;
   logic [LOW_BANK_WIDTH-1:0] low_masked;

   assign offset     = bus_address[OFFSET_WIDTH-1:0];
   assign region     = bus_address[15:13];
   assign upper_used = (size_code >= SIZE_CODE_1M);
   assign low_eff    = (bank.low_bank == '0) ? LOW_BANK_WIDTH'(1) : bank.low_bank;
   assign bank_num   = upper_used ? {bank.high_bank, low_eff}
                                  : {{HIGH_BANK_WIDTH{1'b0}}, low_eff};
   assign low_masked = write_data[LOW_BANK_WIDTH-1:0] & low_mask(size_code);

   always_comb begin
      result.rom_address = '0;
      result.status      = STATUS_UNMAPPED;
      update.low_we      = 1'b0;
      update.high_we     = 1'b0;
      update.mode_we     = 1'b0;
      update.low_bank    = (low_masked == '0) ? LOW_BANK_WIDTH'(1) : low_masked;
      update.high_bank   = write_data[HIGH_BANK_WIDTH-1:0];
      update.bank_mode   = write_data[0];

      if (func == FUNC_WRITE) begin
         case (region)
            REGION_RAM_ENABLE, REGION_RAM_WINDOW: begin
               result.status = STATUS_WRITE_DONE;
            end
            REGION_LOW_BANK: begin
               update.low_we = 1'b1;
               result.status = STATUS_WRITE_DONE;
            end
            REGION_HIGH_BANK: begin
               update.high_we = upper_used;
               result.status  = STATUS_WRITE_DONE;
            end
            REGION_MODE: begin
               update.mode_we = 1'b1;
               result.status  = STATUS_WRITE_DONE;
            end
            default: begin
               result.status = STATUS_UNMAPPED;
            end
         endcase
      end else begin
         case (region)
            REGION_RAM_ENABLE, REGION_LOW_BANK: begin
               // Fixed bank area; in mode one a large ROM maps the high bank here.
               if (upper_used && bank.bank_mode) begin
                  result.rom_address = {bank.high_bank, {LOW_BANK_WIDTH{1'b0}}, offset};
               end else begin
                  result.rom_address = {{BANK_WIDTH{1'b0}}, offset};
               end
               result.status = STATUS_ROM_READ;
            end
            REGION_HIGH_BANK, REGION_MODE: begin
               result.rom_address = {bank_num, offset};
               result.status      = STATUS_ROM_READ;
            end
            REGION_RAM_WINDOW: begin
               result.status = STATUS_OPEN_BUS;
            end
            default: begin
               result.status = STATUS_UNMAPPED;
            end
         endcase
      end
   end

endmodule

FILE: src/mbc1_bank_regs.sv
// ----------------------------------------------------------------------------
// MBC1 bank registers
// Holds the low bank, high bank and mode bit and applies decoded updates.
// ----------------------------------------------------------------------------
module mbc1_bank_regs import mbc1_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            apply,
   input  bank_update_type update,
   output bank_state_type  bank
);

   logic [LOW_BANK_WIDTH-1:0]  low_bank_ff, low_bank_in;
   logic [HIGH_BANK_WIDTH-1:0] high_bank_ff, high_bank_in;
   logic                       bank_mode_ff, bank_mode_in;

   always_comb begin
      low_bank_in  = (apply && update.low_we)  ? update.low_bank  : low_bank_ff;
      high_bank_in = (apply && update.high_we) ? update.high_bank : high_bank_ff;
      bank_mode_in = (apply && update.mode_we) ? update.bank_mode : bank_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_bank_ff  <= LOW_BANK_WIDTH'(1);
         high_bank_ff <= '0;
         bank_mode_ff <= 1'b0;
      end else begin
         low_bank_ff  <= low_bank_in;
         high_bank_ff <= high_bank_in;
         bank_mode_ff <= bank_mode_in;
      end
   end

   assign bank.low_bank  = low_bank_ff;
   assign bank.high_bank = high_bank_ff;
   assign bank.bank_mode = bank_mode_ff;

   // The zero-to-one substitution means the low bank never holds zero.
   assert property (@(posedge clock) disable iff (reset) low_bank_ff != '0)
      else $error("low bank register holds zero");

   // The high bank moves only on an applied high bank write.
   assert property (@(posedge clock) disable iff (reset)
      !(apply && update.high_we) |=> $stable(high_bank_ff))
      else $error("high bank changed without a high bank write");

endmodule

FILE: src/rom_bank_controller_mbc1_unit.sv
// ----------------------------------------------------------------------------
// MBC1 ROM bank controller
// Translates CPU bus accesses into ROM addresses and tracks bank writes.
// ----------------------------------------------------------------------------
// Pipeline: a request beat accepted into the input register moves on into
// the response register, from which it leaves as a response beat (one input
// register, one response register).
// Throughput: one beat per cycle while the response side is ready; the decoder
// is a single short combinational pass between the two registers.
// Reset: synchronous, active high; low bank 1, high bank 0, mode 0 and ROM
// size code 6 (2 MiB); both pipeline stages are emptied.
module rom_bank_controller_mbc1_unit import mbc1_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mbc1_req_if.sink              req_chan,
   mbc1_rsp_if.source            rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [SIZE_WIDTH-1:0] csr_write_data
);

   // Input stage: holds one accepted request beat until the decoder result
   // can move into the response register.
   logic        a_valid_ff, a_valid_in;
   logic        a_func_ff;
   logic [15:0] a_address_ff;
   logic [7:0]  a_data_ff;

   // Response stage.
   logic                      b_valid_ff, b_valid_in;
   logic [ROM_ADDR_WIDTH-1:0] b_rom_address_ff;
   status_type                b_status_ff;

   // ROM size register, written from the configuration port.
   logic [SIZE_WIDTH-1:0] size_code_ff, size_code_in;

   logic            req_accept;
   logic            b_advance;
   logic            a_advance;
   bank_state_type  bank;
   bank_update_type update;
   result_type      result;

   // The response register can take a new beat when it is empty or being
   // drained this cycle. The input stage empties whenever that is so, which
   // keeps the request side flowing at one beat a cycle.
   assign b_advance      = !b_valid_ff || rsp_chan.ready;
   assign a_advance      = a_valid_ff && b_advance;
   assign req_chan.ready = !a_valid_ff || b_advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      if (req_accept) begin
         a_valid_in = 1'b1;
      end else if (b_advance) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
      b_valid_in   = b_advance ? a_valid_ff : b_valid_ff;
      size_code_in = csr_write_enable ? csr_write_data : size_code_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         size_code_ff <= SIZE_CODE_2M;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         size_code_ff <= size_code_in;
      end
   end

   // Payload registers carry no reset; their valid bits qualify them.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_func_ff    <= req_chan.func;
         a_address_ff <= req_chan.bus_address;
         a_data_ff    <= req_chan.write_data;
      end
      if (a_advance) begin
         b_rom_address_ff <= result.rom_address;
         b_status_ff      <= result.status;
      end
   end

   // The decoder sees the bank state left by every earlier beat, because the
   // bank registers are updated in the same cycle that a beat leaves the
   // input stage, before the next beat can be decoded.
   mbc1_decode u_decode (
      .func        (a_func_ff),
      .bus_address (a_address_ff),
      .write_data  (a_data_ff),
      .size_code   (size_code_ff),
      .bank        (bank),
      .result      (result),
      .update      (update)
   );

   mbc1_bank_regs u_bank_regs (
      .clock  (clock),
      .reset  (reset),
      .apply  (a_advance),
      .update (update),
      .bank   (bank)
   );

   assign rsp_chan.valid       = b_valid_ff;
   assign rsp_chan.rom_address = b_rom_address_ff;
   assign rsp_chan.status      = b_status_ff;

   // A beat stalled in the input stage keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !b_advance |=> a_valid_ff && $stable(a_address_ff)
         && $stable(a_func_ff) && $stable(a_data_ff))
      else $error("stalled request beat was lost or altered");

   // Only ROM reads carry a non-zero address.
   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && (b_status_ff != STATUS_ROM_READ) |-> b_rom_address_ff == '0)
      else $error("non-ROM response carries an address");

   // An accepted beat always lands in the input stage.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> a_valid_ff)
      else $error("accepted request beat not captured");

endmodule

FILE: dv/mbc1_translation_checker.sv
// ----------------------------------------------------------------------------
// MBC1 bank controller translation checker
// Watches the request, response and CSR ports of the bank controller. It keeps
// its own copy of the bank registers and predicts each response beat.
// ----------------------------------------------------------------------------
module mbc1_translation_checker import mbc1_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mbc1_req_if                   req_mon,
   mbc1_rsp_if                   rsp_mon,
   input  logic                  csr_write_enable,
   input  logic [SIZE_WIDTH-1:0] csr_write_data,
   output int                    mismatch_count,
   output int                    outstanding_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [SIZE_WIDTH-1:0]      size_code;
   logic [LOW_BANK_WIDTH-1:0]  low_bank;
   logic [HIGH_BANK_WIDTH-1:0] high_bank;
   logic                       bank_mode;

   result_type expected_translations[$];
   int         mismatches = 0;

   // Applies one bus access to the bank registers and returns its response.
   function automatic result_type bank_access(input logic is_write,
                                              input logic [15:0] addr,
                                              input logic [7:0] data);
      result_type                res;
      logic                      wide;
      logic [LOW_BANK_WIDTH-1:0] masked;
      logic [LOW_BANK_WIDTH-1:0] low_sel;
      logic [BANK_WIDTH-1:0]     bank;
      res.rom_address = '0;
      wide = (size_code >= SIZE_CODE_1M);
      if (is_write == FUNC_WRITE) begin
         res.status = STATUS_WRITE_DONE;
         case (addr[15:13])
            REGION_RAM_ENABLE, REGION_RAM_WINDOW: begin
            end
            REGION_LOW_BANK: begin
               masked = data[LOW_BANK_WIDTH-1:0];
               if (size_code <= SIZE_CODE_256K)
                  masked = masked & (5'h1F >> (3'd4 - size_code));
               low_bank = (masked == '0) ? 5'd1 : masked;
            end
            REGION_HIGH_BANK: begin
               if (wide)
                  high_bank = data[HIGH_BANK_WIDTH-1:0];
            end
            REGION_MODE: begin
               bank_mode = data[0];
            end
            default: begin
               res.status = STATUS_UNMAPPED;
            end
         endcase
      end else if (!addr[15]) begin
         res.status = STATUS_ROM_READ;
         if (!addr[14]) begin
            if (wide && bank_mode)
               res.rom_address = {high_bank, 5'd0, addr[OFFSET_WIDTH-1:0]};
            else
               res.rom_address = {7'd0, addr[OFFSET_WIDTH-1:0]};
         end else begin
            low_sel = (low_bank == '0) ? 5'd1 : low_bank;
            bank = wide ? {high_bank, low_sel} : {2'b00, low_sel};
            res.rom_address = {bank, addr[OFFSET_WIDTH-1:0]};
         end
      end else if (addr[15:13] == REGION_RAM_WINDOW) begin
         res.status = STATUS_OPEN_BUS;
      end else begin
         res.status = STATUS_UNMAPPED;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         size_code = SIZE_CODE_2M;
         low_bank  = 5'd1;
         high_bank = 2'd0;
         bank_mode = 1'b0;
         expected_translations.delete();
      end else begin
         if (csr_write_enable)
            size_code = csr_write_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_translations.size() == 0) begin
               $error("unexpected response beat: rom_address %h status %0d",
                      rsp_mon.rom_address, rsp_mon.status);
               mismatches++;
            end else begin
               want = expected_translations.pop_front();
               if (rsp_mon.rom_address !== want.rom_address) begin
                  $error("rom_address mismatch: expected %h, actual %h",
                         want.rom_address, rsp_mon.rom_address);
                  mismatches++;
               end
               if (rsp_mon.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_mon.status);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_translations.push_back(bank_access(req_mon.func,
               req_mon.bus_address, req_mon.write_data));
      end
      mismatch_count    <= mismatches;
      outstanding_count <= expected_translations.size();
   end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// MBC1 bank controller testbench
// Drives bus access beats into the bank controller under several ROM sizes,
// with random idling on both channels, and leaves the prediction and the
// comparison of every response beat to the translation checker.
// ----------------------------------------------------------------------------
module tb_top;
   import mbc1_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // ROM size codes that the package does not name.
   localparam logic [SIZE_WIDTH-1:0] SIZE_CODE_512K     = 3'd4;
   localparam logic [SIZE_WIDTH-1:0] SIZE_CODE_RESERVED = 3'd7;

   localparam int NUM_PHASES      = 9;
   localparam int ITEMS_PER_PHASE = 165;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int CYCLE_LIMIT     = 200000;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [SIZE_WIDTH-1:0] csr_write_data;

   int mismatch_count;
   int outstanding_count;
   int cycle_count;

   // Set by the stimulus to switch random idling off on both channels.
   bit quiet;
   // The stimulus asks for a long receiver hold-off by raising this count;
   // the ready process serves each request once.
   int hold_off_requests;
   int hold_off_served;

   mbc1_req_if req_bus();
   mbc1_rsp_if rsp_bus();

   rom_bank_controller_mbc1_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   mbc1_translation_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_bus),
      .rsp_mon           (rsp_bus),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Watchdog: a healthy run stays well under this limit, so it only
   // trips if a handshake hangs.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // Response side. Ready is dropped at random on about 11 percent of clock edges,
   // except in quiet stretches. A hold-off request keeps ready low for a long
   // run of cycles, so that the pipeline fills and back-pressures the request
   // channel while the sender is still offering beats.
   initial begin
      hold_off_served = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_requests > hold_off_served) begin
            hold_off_served++;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= quiet || ($urandom_range(99) >= 11);
      end
   end

   // Offers one request beat and returns at the edge where it is accepted.
   // Valid is left high, so back-to-back beats need no second assignment in
   // the same time step.
   task automatic send_access(input logic func, input logic [15:0] addr,
                              input logic [7:0] data);
      while (!quiet && $urandom_range(99) < 11) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.func        <= func;
      req_bus.bus_address <= addr;
      req_bus.write_data  <= data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Stops the request channel, waits for every outstanding response beat and
   // the pipeline latency, and only then writes the ROM size register.
   task automatic set_size_code(input logic [SIZE_WIDTH-1:0] code);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding_count != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_write_data   <= code;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [SIZE_WIDTH-1:0] phase_sizes [NUM_PHASES];
      logic                  func;
      logic [15:0]           addr;
      logic [7:0]            data;
      int                    pick;
      phase_sizes = '{SIZE_CODE_32K, SIZE_CODE_2M, SIZE_CODE_256K, SIZE_CODE_1M,
                      SIZE_CODE_64K, SIZE_CODE_512K, SIZE_CODE_128K,
                      SIZE_CODE_RESERVED, SIZE_CODE_2M};
      quiet             = 1'b0;
      hold_off_requests = 0;
      reset               <= 1'b1;
      csr_write_enable    <= 1'b0;
      csr_write_data      <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.func        <= FUNC_READ;
      req_bus.bus_address <= '0;
      req_bus.write_data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first at the reset size of 2 MiB: reset bank state,
      // the zero-to-one bank rule, upper data bits dropped, the mode bit,
      // ignored writes, open bus and unmapped addresses.
      send_access(FUNC_READ,  16'h0000, 8'h00);
      send_access(FUNC_READ,  16'h7FFF, 8'hFF);
      send_access(FUNC_WRITE, 16'h2000, 8'h00);
      send_access(FUNC_WRITE, 16'h3FFF, 8'hFF);
      send_access(FUNC_WRITE, 16'h4000, 8'hFF);
      send_access(FUNC_WRITE, 16'h6000, 8'hFF);
      send_access(FUNC_READ,  16'h0000, 8'h00);
      send_access(FUNC_READ,  16'h4000, 8'h00);
      send_access(FUNC_WRITE, 16'h1FFF, 8'hAA);
      send_access(FUNC_WRITE, 16'hA000, 8'h55);
      send_access(FUNC_READ,  16'hBFFF, 8'h00);
      send_access(FUNC_READ,  16'h8000, 8'h00);
      send_access(FUNC_WRITE, 16'hFFFF, 8'hFF);
      send_access(FUNC_READ,  16'hC000, 8'h00);

      // Shrinking to 32 KiB keeps the banks; the high bank write is dropped
      // and the low bank mask now forces bank one.
      set_size_code(SIZE_CODE_32K);
      send_access(FUNC_READ,  16'h7FFF, 8'h00);
      send_access(FUNC_WRITE, 16'h5FFF, 8'h02);
      send_access(FUNC_WRITE, 16'h2000, 8'hFE);
      send_access(FUNC_READ,  16'h4000, 8'h00);
      send_access(FUNC_READ,  16'h3FFF, 8'h00);

      // The reserved size code acts as 2 MiB, and the held high bank is
      // used again.
      set_size_code(SIZE_CODE_RESERVED);
      send_access(FUNC_READ,  16'h0000, 8'h00);
      send_access(FUNC_WRITE, 16'h4000, 8'h01);
      send_access(FUNC_READ,  16'h6ABC, 8'h00);
      send_access(FUNC_WRITE, 16'h7FFF, 8'h00);
      send_access(FUNC_READ,  16'h2345, 8'h00);

      // Random part. Most beats are bank register writes and ROM reads, which
      // is what exercises the translation; the rest is noise over the whole
      // bus. Phase three runs with no idling at all.
      for (int p = 0; p < NUM_PHASES; p++) begin
         set_size_code(phase_sizes[p]);
         quiet = (p == 3);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ((p == 1 || p == 5) && n == 40)
               hold_off_requests++;
            pick = $urandom_range(99);
            if (pick < 35) begin
               func = FUNC_WRITE;
               addr = {3'($urandom_range(REGION_LOW_BANK, REGION_MODE)),
                       13'($urandom)};
               data = ($urandom_range(99) < 40) ? 8'($urandom_range(0, 3))
                                                : 8'($urandom);
            end else if (pick < 85) begin
               func = FUNC_READ;
               addr = {1'b0, 15'($urandom)};
               data = 8'($urandom);
            end else begin
               func = 1'($urandom);
               addr = 16'($urandom);
               data = 8'($urandom);
            end
            send_access(func, addr, data);
         end
      end
      quiet = 1'b0;

      // Drain: every expected beat must arrive, then the bench keeps waiting to
      // catch any stray response.
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
